### rtl/core/md5_digest_engine_assert.svh
// ----------------------------------------------------------------------------
// md5_digest_engine_assert.svh
// Assertion macros for the MD5 digest engine. Both sample on clk and are
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MD5_DIGEST_ENGINE_ASSERT_SVH
`define MD5_DIGEST_ENGINE_ASSERT_SVH

// same-cycle implication
`define MD5_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("md5 assertion failed");

// next-cycle implication
`define MD5_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("md5 assertion failed");

`endif

### rtl/core/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables of the MD5 digest engine.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int LEN_OFFSET  = 448 / 8;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [15:0][31:0] blk_words_t;
  typedef logic [63:0][7:0]  blk_bytes_t;

  typedef struct packed {
    blk_words_t words;
    logic       fin;
  } blk_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_sts_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_PAD1,
    F_PAD2
  } front_st_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_ADD
  } back_st_t;

  function automatic logic [31:0] round_add(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [3:0] idx);
    logic [4:0] s;
    case (idx)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/core/md5_fifo.sv
// ----------------------------------------------------------------------------
// md5_fifo
// Short block queue between the byte packer and the compression engine.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_fifo import md5_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire blk_t   push_data,
  input  wire logic   pop,
  output blk_t        head,
  output q_sts_t      sts
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  blk_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign sts.full  = (cnt_r == CW'(DEPTH));
  assign sts.empty = (cnt_r == '0);

endmodule

`default_nettype wire

### rtl/core/md5_front.sv
// ----------------------------------------------------------------------------
// md5_front
// Byte packer: packs message bytes into 64-byte blocks, counts the length
// and builds the padding blocks at the end of a message.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_front import md5_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_byte_valid,
  input  wire logic       in_last,
  input  wire q_sts_t     q_sts,
  output logic            q_push,
  output blk_t            q_data
);

  front_st_t   fst_r, fst_nxt;
  logic [63:0] cnt_r, cnt_nxt;
  blk_bytes_t  blk_r, blk_nxt;

  logic        accept;
  logic [5:0]  pos;
  logic [63:0] len_bits;
  logic        fits;
  blk_bytes_t  blk_merge;
  blk_bytes_t  pad_b;
  blk_bytes_t  len_b;

  assign pos      = cnt_r[5:0];
  assign len_bits = {cnt_r[60:0], 3'b000};
  assign fits     = (pos < 6'(LEN_OFFSET));
  assign in_stall = (fst_r != F_IDLE) || q_sts.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    blk_merge      = blk_r;
    blk_merge[pos] = in_data_byte;
  end

  always_comb begin
    for (int j = 0; j < 64; j++) begin
      if (6'(j) < pos) begin
        pad_b[6'(j)] = blk_r[6'(j)];
      end else if (6'(j) == pos) begin
        pad_b[6'(j)] = PAD_BYTE;
      end else begin
        pad_b[6'(j)] = 8'h00;
      end
    end
    if (fits) begin
      pad_b[63:56] = len_bits;
    end
    len_b        = '0;
    len_b[63:56] = len_bits;
  end

  always_comb begin
    fst_nxt = fst_r;
    case (fst_r)
      F_IDLE: begin
        if (accept && in_last) begin
          fst_nxt = F_PAD1;
        end
      end
      F_PAD1: begin
        if (!q_sts.full) begin
          fst_nxt = fits ? F_IDLE : F_PAD2;
        end
      end
      F_PAD2: begin
        if (!q_sts.full) begin
          fst_nxt = F_IDLE;
        end
      end
      default: fst_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    blk_nxt    = blk_r;
    q_push     = 1'b0;
    q_data.words = blk_words_t'(blk_merge);
    q_data.fin   = 1'b0;
    case (fst_r)
      F_IDLE: begin
        if (accept && in_byte_valid) begin
          blk_nxt = blk_merge;
          cnt_nxt = cnt_r + 64'd1;
          q_push  = (pos == 6'd63);
        end
      end
      F_PAD1: begin
        q_data.words = blk_words_t'(pad_b);
        q_data.fin   = fits;
        if (!q_sts.full) begin
          q_push = 1'b1;
          if (fits) begin
            cnt_nxt = '0;
          end
        end
      end
      F_PAD2: begin
        q_data.words = blk_words_t'(len_b);
        q_data.fin   = 1'b1;
        if (!q_sts.full) begin
          q_push  = 1'b1;
          cnt_nxt = '0;
        end
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= F_IDLE;
      cnt_r <= '0;
    end else begin
      fst_r <= fst_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/md5_back.sv
// ----------------------------------------------------------------------------
// md5_back
// Compression engine: one MD5 round per cycle over a queued block, chaining
// update, and the digest output register.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_back import md5_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire blk_t   q_head,
  input  wire q_sts_t q_sts,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic [31:0] out_digest_word0,
  output logic [31:0] out_digest_word1,
  output logic [31:0] out_digest_word2,
  output logic [31:0] out_digest_word3
);

  back_st_t          bst_r, bst_nxt;
  logic [5:0]        rnd_r, rnd_nxt;
  logic [31:0]       a_r, b_r, c_r, d_r;
  logic [31:0]       a_nxt, b_nxt, c_nxt, d_nxt;
  logic [3:0][31:0]  chain_r, chain_nxt;
  logic [3:0][31:0]  dig_r, dig_nxt;
  blk_words_t        msg_r, msg_nxt;
  logic              fin_r, fin_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              out_free;
  logic [31:0]       f;
  logic [3:0]        g;
  logic [3:0]        i4;
  logic [31:0]       sum;
  logic [63:0]       rot_w;
  logic [31:0]       b_new;
  logic [3:0][31:0]  fold;

  assign out_free = !out_valid_r || !out_stall;
  assign i4       = rnd_r[3:0];

  always_comb begin
    case (rnd_r[5:4])
      2'd0: begin
        f = (b_r & c_r) | (~b_r & d_r);
        g = i4;
      end
      2'd1: begin
        f = (d_r & b_r) | (~d_r & c_r);
        g = 4'(i4 * 4'd5 + 4'd1);
      end
      2'd2: begin
        f = b_r ^ c_r ^ d_r;
        g = 4'(i4 * 4'd3 + 4'd5);
      end
      default: begin
        f = c_r ^ (b_r | ~d_r);
        g = 4'(i4 * 4'd7);
      end
    endcase
    sum   = a_r + f + round_add(rnd_r) + msg_r[g];
    rot_w = {sum, sum} << rot_amt({rnd_r[5:4], rnd_r[1:0]});
    b_new = b_r + rot_w[63:32];
  end

  always_comb begin
    fold[0] = chain_r[0] + a_r;
    fold[1] = chain_r[1] + b_r;
    fold[2] = chain_r[2] + c_r;
    fold[3] = chain_r[3] + d_r;
  end

  always_comb begin
    bst_nxt = bst_r;
    case (bst_r)
      B_IDLE: begin
        if (!q_sts.empty) begin
          bst_nxt = B_RUN;
        end
      end
      B_RUN: begin
        if (rnd_r == 6'd63) begin
          bst_nxt = B_ADD;
        end
      end
      B_ADD: begin
        if (!fin_r || out_free) begin
          bst_nxt = B_IDLE;
        end
      end
      default: bst_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    rnd_nxt       = rnd_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    chain_nxt     = chain_r;
    dig_nxt       = dig_r;
    msg_nxt       = msg_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (bst_r)
      B_IDLE: begin
        if (!q_sts.empty) begin
          q_pop   = 1'b1;
          msg_nxt = q_head.words;
          fin_nxt = q_head.fin;
          rnd_nxt = '0;
          a_nxt   = chain_r[0];
          b_nxt   = chain_r[1];
          c_nxt   = chain_r[2];
          d_nxt   = chain_r[3];
        end
      end
      B_RUN: begin
        a_nxt   = d_r;
        b_nxt   = b_new;
        c_nxt   = b_r;
        d_nxt   = c_r;
        rnd_nxt = rnd_r + 6'd1;
      end
      B_ADD: begin
        if (!fin_r) begin
          chain_nxt = fold;
        end else if (out_free) begin
          dig_nxt       = fold;
          out_valid_nxt = 1'b1;
          chain_nxt     = {IV3, IV2, IV1, IV0};
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r       <= B_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
      chain_r     <= {IV3, IV2, IV1, IV0};
    end else begin
      bst_r       <= bst_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
      chain_r     <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    msg_r <= msg_nxt;
    fin_r <= fin_nxt;
    dig_r <= dig_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_digest_word0 = dig_r[0];
  assign out_digest_word1 = dig_r[1];
  assign out_digest_word2 = dig_r[2];
  assign out_digest_word3 = dig_r[3];

endmodule

`default_nettype wire

### rtl/core/md5_digest_engine.sv
// ----------------------------------------------------------------------------
// md5_digest_engine
// Streaming MD5 hasher, one message byte per input word, one digest of four
// words per message on the output channel.
//
// Input: in_data_byte with in_byte_valid, in_last closes the message (a word
// with in_byte_valid low and in_last high ends it without a byte). Output:
// out_digest_word0..3, digest byte 0 in bits 7:0 of word 0.
// A byte is taken while in_valid is high and in_stall low. Every 64 bytes
// form a block that waits in a block queue (FIFO_DEPTH entries) for the
// round engine, which loads it, runs the 64 rounds and does the chaining
// add. in_stall rises while the queue is full and while the padding blocks
// are built after in_last. out_valid rises once the last block has left
// the queue and passed the rounds and final add, behind any queued blocks.
// The digest register holds while out_valid and out_stall are high; the
// engine then waits at its final add, and the packer keeps taking bytes
// until the queue fills. Synchronous reset clears the queue, restores the
// chaining words and zeroes the length; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "md5_digest_engine_assert.svh"

module md5_digest_engine import md5_pkg::*; #(
  parameter int FIFO_DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_valid,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word0,
  output logic [31:0]      out_digest_word1,
  output logic [31:0]      out_digest_word2,
  output logic [31:0]      out_digest_word3
);

  q_sts_t q_sts;
  logic   q_push;
  logic   q_pop;
  blk_t   q_data;
  blk_t   q_head;

  md5_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_byte_valid (in_byte_valid),
    .in_last       (in_last),
    .q_sts         (q_sts),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  md5_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .sts       (q_sts)
  );

  md5_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_head           (q_head),
    .q_sts            (q_sts),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digest_word0 (out_digest_word0),
    .out_digest_word1 (out_digest_word1),
    .out_digest_word2 (out_digest_word2),
    .out_digest_word3 (out_digest_word3)
  );

  `MD5_ASSERT_IMPL(a_no_overflow, q_push, !q_sts.full)
  `MD5_ASSERT_IMPL(a_no_underflow, q_pop, !q_sts.empty)
  `MD5_ASSERT_IMPL(a_take_needs_room, in_valid && !in_stall, !q_sts.full)
  `MD5_ASSERT_NEXT(a_push_lands, q_push && !q_pop, !q_sts.empty)

endmodule

`default_nettype wire
